// File: hw/rtl/kls_pkg.sv
// shared widths, payload types and saturation helper for the leapfrog step core
package kls_pkg;

  localparam int QW      = 32;
  localparam int DtW     = 24;
  localparam int MW      = QW + DtW;
  localparam int R2W     = 2 * QW;
  localparam int SW      = QW;
  localparam int DenW    = R2W + SW;
  localparam int FracW   = 2 * DtW;
  localparam int NumW    = MW + FracW;
  localparam int QuoW    = QW + 2;
  localparam int CmpW    = DenW + QuoW;
  localparam int SatW    = QuoW + 2;
  localparam int SqrtLat = R2W / 2;
  localparam int DivLat  = QuoW + 1;
  localparam int KlsLatency = 7 + SqrtLat + DivLat;

  localparam logic [DtW-1:0]  TimeStepRst = 24'd1677722;
  localparam logic [QuoW-1:0] KickCap = {2'b10, {(QuoW-2){1'b0}}};
  localparam logic signed [SatW-1:0] SatHi = {{(SatW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [SatW-1:0] SatLo = {{(SatW-QW+1){1'b1}}, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [QW-1:0] px;
    logic signed [QW-1:0] py;
    logic signed [QW-1:0] vx;
    logic signed [QW-1:0] vy;
    logic [MW-1:0]        mx;
    logic [MW-1:0]        my;
    logic [R2W-1:0]       r2;
    logic                 zero;
  } kin_t;

  typedef struct packed {
    logic signed [QW-1:0] px;
    logic signed [QW-1:0] py;
    logic signed [QW-1:0] vx;
    logic signed [QW-1:0] vy;
    logic                 zero;
  } carry_t;

  // returns {clip, value}
  function automatic logic [QW:0] sat_q(input logic signed [SatW-1:0] v);
    priority if (v > SatHi) begin
      return {1'b1, SatHi[QW-1:0]};
    end else if (v < SatLo) begin
      return {1'b1, SatLo[QW-1:0]};
    end else begin
      return {1'b0, v[QW-1:0]};
    end
  endfunction

endpackage

// File: hw/rtl/kls_sqrt.sv
// pipelined integer square root, one result bit per stage, payload carried alongside
module kls_sqrt import kls_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  kin_t          in_kin_i,
  output logic          out_valid_o,
  output kin_t          out_kin_o,
  output logic [SW-1:0] out_root_o
);

  localparam int Steps = R2W / 2;

  logic           vld_q [Steps];
  kin_t           kin_q [Steps];
  logic [R2W-1:0] n_q   [Steps];
  logic [R2W-1:0] res_q [Steps];

  for (genvar g = 0; g < Steps; g++) begin : g_stage
    localparam logic [R2W-1:0] StepBit = R2W'(1) << (R2W - 2 - 2 * g);
    logic           vld_in;
    kin_t           kin_in;
    logic [R2W-1:0] n_in, res_in, n_d, res_d, trial;

    if (g == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign kin_in = in_kin_i;
      assign n_in   = in_kin_i.r2;
      assign res_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[g-1];
      assign kin_in = kin_q[g-1];
      assign n_in   = n_q[g-1];
      assign res_in = res_q[g-1];
    end

    always_comb begin
      trial = res_in + StepBit;
      if (n_in >= trial) begin
        n_d   = n_in - trial;
        res_d = (res_in >> 1) + StepBit;
      end else begin
        n_d   = n_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      kin_q[g] <= kin_in;
      n_q[g]   <= n_d;
      res_q[g] <= res_d;
    end
  end

  assign out_valid_o = vld_q[Steps-1];
  assign out_kin_o   = kin_q[Steps-1];
  assign out_root_o  = res_q[Steps-1][SW-1:0];

endmodule

// File: hw/rtl/kls_div.sv
// pipelined restoring divider for both kick lanes sharing one denominator
module kls_div import kls_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [DenW-1:0]           in_den_i,
  input  logic [1:0][NumW-1:0]      in_num_i,
  input  carry_t                    in_carry_i,
  output logic                      out_valid_o,
  output logic [1:0][QuoW-1:0]      out_quo_o,
  output logic [1:0]                out_ovf_o,
  output carry_t                    out_carry_o
);

  localparam int Steps = QuoW;
  localparam int PadW  = CmpW - NumW;

  logic                 vld_q   [Steps+1];
  logic [DenW-1:0]      den_q   [Steps+1];
  logic [1:0][NumW-1:0] rem_q   [Steps+1];
  logic [1:0][QuoW-1:0] quo_q   [Steps+1];
  logic [1:0]           ovf_q   [Steps+1];
  carry_t               carry_q [Steps+1];

  // overflow check: quotient would need more than QuoW bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0]   <= in_den_i;
    rem_q[0]   <= in_num_i;
    quo_q[0]   <= '0;
    carry_q[0] <= in_carry_i;
    for (int l = 0; l < 2; l++) begin
      ovf_q[0][l] <= {{PadW{1'b0}}, in_num_i[l]} >= {in_den_i, {QuoW{1'b0}}};
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_stage
    localparam int Sh = Steps - 1 - g;
    logic [CmpW-1:0]      den_sh;
    logic [1:0]           ge;
    logic [1:0][NumW-1:0] rem_d;
    logic [1:0][QuoW-1:0] quo_d;

    always_comb begin
      den_sh = {{QuoW{1'b0}}, den_q[g]} << Sh;
      for (int l = 0; l < 2; l++) begin
        ge[l]    = {{PadW{1'b0}}, rem_q[g][l]} >= den_sh;
        rem_d[l] = ge[l] ? rem_q[g][l] - den_sh[NumW-1:0] : rem_q[g][l];
        quo_d[l] = quo_q[g][l] | (QuoW'(ge[l]) << Sh);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[g+1]   <= den_q[g];
      rem_q[g+1]   <= rem_d;
      quo_q[g+1]   <= quo_d;
      ovf_q[g+1]   <= ovf_q[g];
      carry_q[g+1] <= carry_q[g];
    end
  end

  assign out_valid_o = vld_q[Steps];
  assign out_quo_o   = quo_q[Steps];
  assign out_ovf_o   = ovf_q[Steps];
  assign out_carry_o = carry_q[Steps];

endmodule

// File: hw/rtl/kepler_leapfrog_step_core.sv
// top level of the leapfrog kick-drift step core for a 2-D inverse-square field
//
//  channel   | direction | transfer when       | payload
//  ----------+-----------+---------------------+-------------------------------------------
//  item in   | in        | start_i && !busy_o  | pos_x_i pos_y_i vel_x_i vel_y_i
//  result    | out       | done_o              | new_pos_*_o new_vel_*_o saturated_o
//  time step | in        | cfg_we_i            | cfg_wdata_i
//
//  one item per cycle
//  each item passes through the 32-stage square root and the 35-stage kick divider
//  busy_o stays low: the pipeline never stalls and the receiver cannot hold off
//  reset clears all stage valid bits and loads time step 1677722
module kepler_leapfrog_step_core import kls_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [QW-1:0] pos_x_i,
  input  logic signed [QW-1:0] pos_y_i,
  input  logic signed [QW-1:0] vel_x_i,
  input  logic signed [QW-1:0] vel_y_i,
  input  logic                 cfg_we_i,
  input  logic [DtW-1:0]       cfg_wdata_i,
  output logic                 done_o,
  output logic signed [QW-1:0] new_pos_x_o,
  output logic signed [QW-1:0] new_pos_y_o,
  output logic signed [QW-1:0] new_vel_x_o,
  output logic signed [QW-1:0] new_vel_y_o,
  output logic                 saturated_o
);

  logic [DtW-1:0] time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TimeStepRst;
    end else if (cfg_we_i) begin
      time_step_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  // stage a: magnitudes squared and scaled by dt
  logic              vld_a_q;
  logic [QW-1:0]     ax, ay;
  logic signed [QW-1:0] px_a_q, py_a_q, vx_a_q, vy_a_q;
  logic [R2W-1:0]    sqx_a_q, sqy_a_q;
  logic [MW-1:0]     mx_a_q, my_a_q;

  assign ax = pos_x_i[QW-1] ? ~pos_x_i + 1'b1 : pos_x_i;
  assign ay = pos_y_i[QW-1] ? ~pos_y_i + 1'b1 : pos_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    px_a_q  <= pos_x_i;
    py_a_q  <= pos_y_i;
    vx_a_q  <= vel_x_i;
    vy_a_q  <= vel_y_i;
    sqx_a_q <= R2W'(ax) * R2W'(ax);
    sqy_a_q <= R2W'(ay) * R2W'(ay);
    mx_a_q  <= MW'(ax) * MW'(time_step_q);
    my_a_q  <= MW'(ay) * MW'(time_step_q);
  end

  // stage b: squared radius
  logic vld_b_q;
  kin_t kin_b_q, kin_b_d;

  always_comb begin
    kin_b_d.px   = px_a_q;
    kin_b_d.py   = py_a_q;
    kin_b_d.vx   = vx_a_q;
    kin_b_d.vy   = vy_a_q;
    kin_b_d.mx   = mx_a_q;
    kin_b_d.my   = my_a_q;
    kin_b_d.r2   = sqx_a_q + sqy_a_q;
    kin_b_d.zero = (kin_b_d.r2 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kin_b_q <= kin_b_d;
  end

  logic          vld_s;
  kin_t          kin_s;
  logic [SW-1:0] root_s;

  kls_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vld_b_q),
    .in_kin_i   (kin_b_q),
    .out_valid_o(vld_s),
    .out_kin_o  (kin_s),
    .out_root_o (root_s)
  );

  // stage c: r2 times root as two partial products
  logic                 vld_c_q;
  logic [2*SW-1:0]      plo_c_q, phi_c_q;
  logic [1:0][NumW-1:0] num_c_q;
  carry_t               carry_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= vld_s;
    end
  end

  always_ff @(posedge clk_i) begin
    plo_c_q         <= (2*SW)'(kin_s.r2[SW-1:0]) * (2*SW)'(root_s);
    phi_c_q         <= (2*SW)'(kin_s.r2[R2W-1:SW]) * (2*SW)'(root_s);
    num_c_q[0]      <= {kin_s.mx, {FracW{1'b0}}};
    num_c_q[1]      <= {kin_s.my, {FracW{1'b0}}};
    carry_c_q.px    <= kin_s.px;
    carry_c_q.py    <= kin_s.py;
    carry_c_q.vx    <= kin_s.vx;
    carry_c_q.vy    <= kin_s.vy;
    carry_c_q.zero  <= kin_s.zero;
  end

  // stage d: denominator r^3
  logic                 vld_d_q;
  logic [DenW-1:0]      den_d_q;
  logic [1:0][NumW-1:0] num_d_q;
  carry_t               carry_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    den_d_q   <= {{(DenW-2*SW){1'b0}}, plo_c_q} + {phi_c_q, {SW{1'b0}}};
    num_d_q   <= num_c_q;
    carry_d_q <= carry_c_q;
  end

  logic                 vld_v;
  logic [1:0][QuoW-1:0] quo_v;
  logic [1:0]           ovf_v;
  carry_t               carry_v;

  kls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vld_d_q),
    .in_den_i   (den_d_q),
    .in_num_i   (num_d_q),
    .in_carry_i (carry_d_q),
    .out_valid_o(vld_v),
    .out_quo_o  (quo_v),
    .out_ovf_o  (ovf_v),
    .out_carry_o(carry_v)
  );

  // stage e: kick velocities
  logic signed [QW-1:0] p_v [2];
  logic signed [QW-1:0] v_v [2];
  logic [QuoW-1:0]      kick [2];
  logic signed [SatW-1:0] vsum [2];
  logic [QW:0]          nv_sat [2];

  logic                 vld_e_q, flag_e_q;
  logic signed [QW-1:0] p_e_q  [2];
  logic signed [QW-1:0] nv_e_q [2];

  assign p_v[0] = carry_v.px;
  assign p_v[1] = carry_v.py;
  assign v_v[0] = carry_v.vx;
  assign v_v[1] = carry_v.vy;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      kick[l] = (ovf_v[l] || quo_v[l] > KickCap) ? KickCap : quo_v[l];
      vsum[l] = p_v[l][QW-1]
              ? {{(SatW-QW){v_v[l][QW-1]}}, v_v[l]} + {{(SatW-QuoW){1'b0}}, kick[l]}
              : {{(SatW-QW){v_v[l][QW-1]}}, v_v[l]} - {{(SatW-QuoW){1'b0}}, kick[l]};
      nv_sat[l] = carry_v.zero ? {1'b0, v_v[l]} : sat_q(vsum[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else begin
      vld_e_q <= vld_v;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_e_q <= carry_v.zero | nv_sat[0][QW] | nv_sat[1][QW];
    for (int l = 0; l < 2; l++) begin
      p_e_q[l]  <= p_v[l];
      nv_e_q[l] <= nv_sat[l][QW-1:0];
    end
  end

  // stage f: drift magnitude
  logic [QW-1:0] nv_mag [2];
  logic [MW-1:0] drift_prod [2];

  logic                 vld_f_q, flag_f_q;
  logic signed [QW-1:0] p_f_q  [2];
  logic signed [QW-1:0] nv_f_q [2];
  logic [QW-1:0]        d_f_q  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nv_mag[l]     = nv_e_q[l][QW-1] ? ~nv_e_q[l] + 1'b1 : nv_e_q[l];
      drift_prod[l] = MW'(nv_mag[l]) * MW'(time_step_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else begin
      vld_f_q <= vld_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_f_q <= flag_e_q;
    for (int l = 0; l < 2; l++) begin
      p_f_q[l]  <= p_e_q[l];
      nv_f_q[l] <= nv_e_q[l];
      d_f_q[l]  <= drift_prod[l][MW-1:DtW];
    end
  end

  // stage g: drift positions, output register
  logic signed [SatW-1:0] psum [2];
  logic [QW:0]            np_sat [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      psum[l] = nv_f_q[l][QW-1]
              ? {{(SatW-QW){p_f_q[l][QW-1]}}, p_f_q[l]} - {{(SatW-QW){1'b0}}, d_f_q[l]}
              : {{(SatW-QW){p_f_q[l][QW-1]}}, p_f_q[l]} + {{(SatW-QW){1'b0}}, d_f_q[l]};
      np_sat[l] = sat_q(psum[l]);
    end
  end

  logic                 done_q;
  logic signed [QW-1:0] new_pos_x_q, new_pos_y_q, new_vel_x_q, new_vel_y_q;
  logic                 saturated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    new_pos_x_q <= np_sat[0][QW-1:0];
    new_pos_y_q <= np_sat[1][QW-1:0];
    new_vel_x_q <= nv_f_q[0];
    new_vel_y_q <= nv_f_q[1];
    saturated_q <= flag_f_q | np_sat[0][QW] | np_sat[1][QW];
  end

  assign done_o      = done_q;
  assign new_pos_x_o = new_pos_x_q;
  assign new_pos_y_o = new_pos_y_q;
  assign new_vel_x_o = new_vel_x_q;
  assign new_vel_y_o = new_vel_y_q;
  assign saturated_o = saturated_q;

endmodule

// File: hw/rtl/kls_chk.sv
// port-level checker for the leapfrog step core, bound to the top level
module kls_chk import kls_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic signed [QW-1:0] pos_x_i,
  input logic signed [QW-1:0] pos_y_i,
  input logic signed [QW-1:0] vel_x_i,
  input logic signed [QW-1:0] vel_y_i,
  input logic                 cfg_we_i,
  input logic [DtW-1:0]       cfg_wdata_i,
  input logic                 done_o,
  input logic signed [QW-1:0] new_pos_x_o,
  input logic signed [QW-1:0] new_pos_y_o,
  input logic signed [QW-1:0] new_vel_x_o,
  input logic signed [QW-1:0] new_vel_y_o,
  input logic                 saturated_o
);

  logic in_xfer, zero_in;

  assign in_xfer = start_i && !busy_o;
  assign zero_in = in_xfer && pos_x_i == '0 && pos_y_i == '0;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##KlsLatency done_o)
    else $error("transfer in without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_xfer, KlsLatency))
    else $error("result without transfer in");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_in |-> ##KlsLatency saturated_o)
    else $error("zero radius not flagged");

  a_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_in |-> ##KlsLatency (new_vel_x_o == $past(vel_x_i, KlsLatency)
                             && new_vel_y_o == $past(vel_y_i, KlsLatency)))
    else $error("zero radius changed velocity");

endmodule

bind kepler_leapfrog_step_core kls_chk u_kls_chk (.*);
